// ===== sv/cmlb_pkg.sv =====
// ----------------------------------------------------------------------------
// cmlb_pkg
// shared types and constants for the move/load/branch executor
// ----------------------------------------------------------------------------
`default_nettype none
package cmlb_pkg;
	localparam logic [1:0] MODE_MEM  = 2'd0;
	localparam logic [1:0] MODE_EXEC = 2'd1;
	localparam logic [1:0] MODE_FLAG = 2'd2;

	localparam logic [15:0] SP_RESET = 16'hFFFF;

	localparam logic [2:0] R_B = 3'd0;
	localparam logic [2:0] R_C = 3'd1;
	localparam logic [2:0] R_D = 3'd2;
	localparam logic [2:0] R_E = 3'd3;
	localparam logic [2:0] R_H = 3'd4;
	localparam logic [2:0] R_L = 3'd5;
	localparam logic [2:0] R_M = 3'd6;
	localparam logic [2:0] R_A = 3'd7;

	typedef struct packed {
		logic        we;
		logic [15:0] addr;
		logic [7:0]  wdata;
	} mem_req_t;

	function automatic logic cond_true(input logic [2:0] ccc, input logic [3:0] f);
		logic r;
		unique case (ccc)
			3'd0: r = ~f[2];
			3'd1: r = f[2];
			3'd2: r = ~f[0];
			3'd3: r = f[0];
			3'd4: r = ~f[1];
			3'd5: r = f[1];
			3'd6: r = ~f[3];
			default: r = f[3];
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== sv/cmlb_mem.sv =====
// ----------------------------------------------------------------------------
// cmlb_mem
// byte memory, one port, registered read, with clear sweep after reset
// ----------------------------------------------------------------------------
`default_nettype none
module cmlb_mem import cmlb_pkg::*; #(
	parameter int ADDR_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire mem_req_t    req,
	output logic [7:0]       rdata,
	output logic             busy
);
	logic [7:0] mem [2**ADDR_BITS];
	logic [ADDR_BITS:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (!clr_q[ADDR_BITS]) clr_q <= clr_q + 1'b1;
	end

	assign busy = !clr_q[ADDR_BITS];

	always_ff @(posedge clk) begin
		if (busy) mem[clr_q[ADDR_BITS-1:0]] <= 8'h00;
		else if (req.we) mem[req.addr[ADDR_BITS-1:0]] <= req.wdata;
		rdata <= mem[req.addr[ADDR_BITS-1:0]];
	end
endmodule
`default_nettype wire

// ===== sv/cpu_move_load_branch_executor.sv =====
// ----------------------------------------------------------------------------
// cpu_move_load_branch_executor
// data transfer and branch subset of an 8-bit cpu with private memory
// ----------------------------------------------------------------------------
// input channel (valid/ready) carries mode, address and data; each transfer
// yields one snapshot of the registers on the output channel.
// mode 0 writes a memory byte, mode 2 loads flags, mode 1 runs one
// instruction fetched at pc. every memory access goes through the single
// memory port, whose read is registered; an instruction fetches its bytes
// and reads or writes its operand bytes one at a time through that port.
// after reset the memory is swept to zero with ready low; registers reset at
// once, sp to 0xffff.
// the result waits in an output register; while it is not taken the block
// accepts no new item.
// ----------------------------------------------------------------------------
`default_nettype none
module cpu_move_load_branch_executor import cmlb_pkg::*; #(
	parameter int ADDR_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  mode,
	input  wire logic [15:0] address,
	input  wire logic [7:0]  data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      pc,
	output logic [7:0]       acc,
	output logic [7:0]       reg_b,
	output logic [7:0]       reg_c,
	output logic [7:0]       reg_d,
	output logic [7:0]       reg_e,
	output logic [7:0]       reg_h,
	output logic [7:0]       reg_l,
	output logic [15:0]      stack_ptr,
	output logic [7:0]       opcode,
	output logic             unknown_op
);
	typedef enum logic [3:0] {
		S_IDLE, S_OPW, S_OPD, S_LOW, S_LOD, S_HIW, S_HID, S_RD1, S_RD2,
		S_WR2, S_DONE
	} state_t;

	state_t state_q;
	mem_req_t req;
	logic [7:0] rdata;
	logic busy;

	logic [15:0] pc_q, sp_q, adr_q;
	logic [7:0] rf_q [8];
	logic [3:0] flg_q;
	logic [7:0] op_q, lo_q, wd2_q;
	logic unk_q;

	cmlb_mem #(.ADDR_BITS(ADDR_BITS)) u_mem (
		.clk(clk), .arst_n(arst_n), .req(req), .rdata(rdata), .busy(busy)
	);

	logic [15:0] hl, bc, de, word;
	assign hl = {rf_q[R_H], rf_q[R_L]};
	assign bc = {rf_q[R_B], rf_q[R_C]};
	assign de = {rf_q[R_D], rf_q[R_E]};
	assign word = {rdata, lo_q};

	// operand kinds of the current opcode
	logic is_mov, is_mvi, is_jcc, is_ccc;
	always_comb begin
		is_mov = op_q[7:6] == 2'b01 && op_q != 8'h76;
		is_mvi = (op_q & 8'hC7) == 8'h06;
		is_jcc = (op_q & 8'hC7) == 8'hC2;
		is_ccc = (op_q & 8'hC7) == 8'hC4;
	end

	always_comb begin
		req = '{we: 1'b0, addr: pc_q, wdata: 8'h00};
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready && mode == MODE_MEM)
					req = '{we: 1'b1, addr: address, wdata: data};
			end
			S_RD1, S_RD2, S_WR2, S_LOW, S_HIW, S_OPW: req.addr = adr_q;
			default: ;
		endcase
		if (state_q == S_RD1) begin
			// write of the operand, or of the first of its two bytes
			req.we = (op_q[7:6] == 2'b01 && op_q[5:3] == R_M) || op_q == 8'h02 ||
				op_q == 8'h12 || op_q == 8'h32 || op_q == 8'h22 || is_mvi || is_ccc ||
				op_q == 8'hCD;
			req.wdata = wd2_q;
		end else if (state_q == S_WR2) begin
			req.we = op_q == 8'h22 || is_ccc || op_q == 8'hCD;
			req.wdata = lo_q;
		end
	end

	assign in_ready = state_q == S_IDLE && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q <= '0;
			sp_q <= SP_RESET;
			flg_q <= '0;
			for (int i = 0; i < 8; i++) rf_q[i] <= '0;
			out_valid <= 1'b0;
			op_q <= '0;
			unk_q <= 1'b0;
			adr_q <= '0;
			lo_q <= '0;
			wd2_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						op_q <= '0;
						unk_q <= 1'b0;
						if (mode == MODE_FLAG) flg_q <= data[3:0];
						if (mode == MODE_EXEC) begin
							adr_q <= pc_q;
							pc_q <= pc_q + 16'd1;
							state_q <= S_OPW;
						end else state_q <= S_DONE;
					end
				end
				S_OPW: state_q <= S_OPD;
				S_OPD: begin
					op_q <= rdata;
					adr_q <= pc_q;
					state_q <= S_LOW;
					if (rdata[7:6] == 2'b01 && rdata != 8'h76) begin
						if (rdata[2:0] == R_M) begin
							adr_q <= hl;
							state_q <= S_LOW;
						end else if (rdata[5:3] == R_M) begin
							adr_q <= hl;
							wd2_q <= rf_q[{rdata[2:1] == 2'b11 ? R_A[2:1] : rdata[2:1],
								rdata[0]}];
							state_q <= S_RD1;
						end else begin
							rf_q[rdata[5:3] == R_M ? R_A : rdata[5:3]] <=
								rf_q[rdata[2:0]];
							state_q <= S_DONE;
						end
					end else if (rdata == 8'h0A || rdata == 8'h1A) begin
						adr_q <= rdata[4] ? de : bc;
						state_q <= S_LOW;
					end else if (rdata == 8'h02 || rdata == 8'h12) begin
						adr_q <= rdata[4] ? de : bc;
						wd2_q <= rf_q[R_A];
						state_q <= S_RD1;
					end else if (rdata == 8'hEB) begin
						rf_q[R_H] <= rf_q[R_D];
						rf_q[R_L] <= rf_q[R_E];
						rf_q[R_D] <= rf_q[R_H];
						rf_q[R_E] <= rf_q[R_L];
						state_q <= S_DONE;
					end else if ((rdata & 8'hC7) != 8'h06 && !(rdata == 8'h01 ||
						rdata == 8'h11 || rdata == 8'h21 || rdata == 8'h31 ||
						rdata == 8'h3A || rdata == 8'h32 || rdata == 8'h2A ||
						rdata == 8'h22 || rdata == 8'hC3 || rdata == 8'hCD ||
						(rdata & 8'hC7) == 8'hC2 || (rdata & 8'hC7) == 8'hC4)) begin
						unk_q <= 1'b1;
						state_q <= S_DONE;
					end else pc_q <= pc_q + 16'd1;
					if (rdata[7:6] == 2'b01 && rdata == 8'h76) begin
						unk_q <= 1'b1;
						state_q <= S_DONE;
					end
				end
				S_LOW: state_q <= S_LOD;
				S_LOD: begin
					// first byte after fetch or operand read
					if (is_mov) begin
						rf_q[op_q[5:3]] <= rdata;
						state_q <= S_DONE;
					end else if (op_q == 8'h0A || op_q == 8'h1A) begin
						rf_q[R_A] <= rdata;
						state_q <= S_DONE;
					end else if (is_mvi) begin
						if (op_q[5:3] == R_M) begin
							adr_q <= hl;
							wd2_q <= rdata;
							state_q <= S_RD1;
						end else begin
							rf_q[op_q[5:3]] <= rdata;
							state_q <= S_DONE;
						end
					end else begin
						lo_q <= rdata;
						adr_q <= pc_q;
						pc_q <= pc_q + 16'd1;
						state_q <= S_HIW;
					end
				end
				S_HIW: state_q <= S_HID;
				S_HID: begin
					state_q <= S_DONE;
					unique case (op_q)
						8'h01: {rf_q[R_B], rf_q[R_C]} <= word;
						8'h11: {rf_q[R_D], rf_q[R_E]} <= word;
						8'h21: {rf_q[R_H], rf_q[R_L]} <= word;
						8'h31: sp_q <= word;
						8'hC3: pc_q <= word;
						8'h3A: begin adr_q <= word; state_q <= S_RD2; end
						8'h32: begin adr_q <= word; wd2_q <= rf_q[R_A]; state_q <= S_RD1; end
						8'h2A: begin adr_q <= word; lo_q <= 8'h00; state_q <= S_RD2; end
						8'h22: begin
							adr_q <= word;
							wd2_q <= rf_q[R_L];
							lo_q <= rf_q[R_H];
							state_q <= S_RD1;
						end
						default: begin
							if (is_jcc) begin
								if (cond_true(op_q[5:3], flg_q)) pc_q <= word;
							end else if (op_q == 8'hCD || cond_true(op_q[5:3], flg_q)) begin
								adr_q <= sp_q - 16'd1;
								sp_q <= sp_q - 16'd2;
								wd2_q <= pc_q[15:8];
								lo_q <= pc_q[7:0];
								pc_q <= word;
								state_q <= S_RD1;
							end
						end
					endcase
				end
				S_RD2: state_q <= S_WR2;
				S_RD1: begin
					if (op_q == 8'h22) begin
						adr_q <= adr_q + 16'd1;
						state_q <= S_WR2;
					end else if (is_ccc || op_q == 8'hCD) begin
						adr_q <= adr_q - 16'd1;
						state_q <= S_WR2;
					end else state_q <= S_DONE;
				end
				S_WR2: begin
					if (op_q == 8'h3A) begin
						rf_q[R_A] <= rdata;
						state_q <= S_DONE;
					end else if (op_q == 8'h2A && lo_q != 8'hFF) begin
						rf_q[R_L] <= rdata;
						adr_q <= adr_q + 16'd1;
						lo_q <= 8'hFF;
						state_q <= S_RD2;
					end else begin
						if (op_q == 8'h2A) rf_q[R_H] <= rdata;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid) out_valid <= 1'b1;
					else if (out_ready) begin
						out_valid <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign pc = pc_q;
	assign acc = rf_q[R_A];
	assign reg_b = rf_q[R_B];
	assign reg_c = rf_q[R_C];
	assign reg_d = rf_q[R_D];
	assign reg_e = rf_q[R_E];
	assign reg_h = rf_q[R_H];
	assign reg_l = rf_q[R_L];
	assign stack_ptr = sp_q;
	assign opcode = op_q;
	assign unknown_op = unk_q;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !in_ready) else $error("accept during clear");
	a_unk_op: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && unknown_op |-> !is_mov && !is_mvi && !is_jcc && !is_ccc)
		else $error("unknown flag");
	a_out_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == S_DONE) else $error("result outside done");
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// regression for cpu_move_load_branch_executor: directed programs, random
// instruction streams and flag loads, each snapshot checked against a local
// model of the cpu with random idling and stalls on both channels
// ----------------------------------------------------------------------------
`default_nettype none
module testbench import cmlb_pkg::*;;

	localparam logic [7:0] OP_NOP     = 8'h00;
	localparam logic [7:0] OP_LXI_B   = 8'h01;
	localparam logic [7:0] OP_STAX_B  = 8'h02;
	localparam logic [7:0] OP_LDAX_B  = 8'h0A;
	localparam logic [7:0] OP_LXI_D   = 8'h11;
	localparam logic [7:0] OP_STAX_D  = 8'h12;
	localparam logic [7:0] OP_LDAX_D  = 8'h1A;
	localparam logic [7:0] OP_LXI_H   = 8'h21;
	localparam logic [7:0] OP_SHLD    = 8'h22;
	localparam logic [7:0] OP_LHLD    = 8'h2A;
	localparam logic [7:0] OP_LXI_SP  = 8'h31;
	localparam logic [7:0] OP_STA     = 8'h32;
	localparam logic [7:0] OP_MVI_M   = 8'h36;
	localparam logic [7:0] OP_LDA     = 8'h3A;
	localparam logic [7:0] OP_MOV_M_B = 8'h70;
	localparam logic [7:0] OP_HLT     = 8'h76;
	localparam logic [7:0] OP_MOV_A_M = 8'h7E;
	localparam logic [7:0] OP_CNZ     = 8'hC4;
	localparam logic [7:0] OP_JMP     = 8'hC3;
	localparam logic [7:0] OP_JZ      = 8'hCA;
	localparam logic [7:0] OP_CALL    = 8'hCD;
	localparam logic [7:0] OP_JPE     = 8'hEA;
	localparam logic [7:0] OP_XCHG    = 8'hEB;
	localparam logic [7:0] OP_CM      = 8'hFC;
	localparam logic [1:0] MODE_NONE  = 2'd3;

	localparam int FLAG_S = 3;
	localparam int FLAG_Z = 2;
	localparam int FLAG_P = 1;
	localparam int FLAG_C = 0;

	localparam int ITEM_TARGET = 1250;
	localparam int LONG_HOLD   = 300;

	typedef struct packed {
		logic [15:0] pc;
		logic [7:0]  acc;
		logic [7:0]  b;
		logic [7:0]  c;
		logic [7:0]  d;
		logic [7:0]  e;
		logic [7:0]  h;
		logic [7:0]  l;
		logic [15:0] sp;
		logic [7:0]  op;
		logic        unk;
	} snapshot_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  mode;
	logic [15:0] address;
	logic [7:0]  data;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] pc;
	logic [7:0]  acc;
	logic [7:0]  reg_b;
	logic [7:0]  reg_c;
	logic [7:0]  reg_d;
	logic [7:0]  reg_e;
	logic [7:0]  reg_h;
	logic [7:0]  reg_l;
	logic [15:0] stack_ptr;
	logic [7:0]  opcode;
	logic        unknown_op;

	cpu_move_load_branch_executor dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .address(address), .data(data),
		.out_valid(out_valid), .out_ready(out_ready),
		.pc(pc), .acc(acc), .reg_b(reg_b), .reg_c(reg_c), .reg_d(reg_d),
		.reg_e(reg_e), .reg_h(reg_h), .reg_l(reg_l), .stack_ptr(stack_ptr),
		.opcode(opcode), .unknown_op(unknown_op)
	);

	// cpu model state
	bit [7:0]  mem_img [0:65535];
	bit [7:0]  regs [0:7];
	bit [15:0] pc_m = 16'h0000;
	bit [15:0] sp_m = SP_RESET;
	bit [3:0]  flags_m = 4'h0;

	snapshot_t expected_snaps [$];
	int        items_sent = 0;
	int        mismatches = 0;
	bit        burst_mode = 0;
	bit        long_hold = 0;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("cpu_move_load_branch_executor regression: fail");
		$finish;
	end

	function automatic bit [7:0] fetch_byte();
		bit [7:0] v;
		v = mem_img[pc_m];
		pc_m = pc_m + 16'd1;
		return v;
	endfunction

	function automatic bit [15:0] fetch_word();
		bit [7:0] lo;
		lo = fetch_byte();
		return {fetch_byte(), lo};
	endfunction

	function automatic bit [7:0] read_operand(input bit [2:0] code);
		if (code == R_M)
			return mem_img[{regs[R_H], regs[R_L]}];
		return regs[code];
	endfunction

	function automatic void write_operand(input bit [2:0] code, input bit [7:0] v);
		if (code == R_M)
			mem_img[{regs[R_H], regs[R_L]}] = v;
		else
			regs[code] = v;
	endfunction

	function automatic bit condition_met(input bit [2:0] ccc);
		bit f;
		case (ccc[2:1])
			2'd0: f = flags_m[FLAG_Z];
			2'd1: f = flags_m[FLAG_C];
			2'd2: f = flags_m[FLAG_P];
			default: f = flags_m[FLAG_S];
		endcase
		return f == ccc[0];
	endfunction

	function automatic void push_return(input bit [15:0] v);
		sp_m = sp_m - 16'd1;
		mem_img[sp_m] = v[15:8];
		sp_m = sp_m - 16'd1;
		mem_img[sp_m] = v[7:0];
	endfunction

	// returns 1 for an opcode outside the subset
	function automatic bit execute_op(input bit [7:0] op);
		bit [15:0] w;
		bit [15:0] t;
		if (op[7:6] == 2'b01) begin
			if (op == OP_HLT)
				return 1;
			write_operand(op[5:3], read_operand(op[2:0]));
			return 0;
		end
		if (op[7:6] == 2'b00 && op[2:0] == 3'b110) begin
			write_operand(op[5:3], fetch_byte());
			return 0;
		end
		if (op[7:6] == 2'b11 && op[2:0] == 3'b010) begin
			w = fetch_word();
			if (condition_met(op[5:3]))
				pc_m = w;
			return 0;
		end
		if (op[7:6] == 2'b11 && op[2:0] == 3'b100) begin
			w = fetch_word();
			if (condition_met(op[5:3])) begin
				push_return(pc_m);
				pc_m = w;
			end
			return 0;
		end
		case (op)
			OP_LXI_B: {regs[R_B], regs[R_C]} = fetch_word();
			OP_LXI_D: {regs[R_D], regs[R_E]} = fetch_word();
			OP_LXI_H: {regs[R_H], regs[R_L]} = fetch_word();
			OP_LXI_SP: sp_m = fetch_word();
			OP_LDAX_B: regs[R_A] = mem_img[{regs[R_B], regs[R_C]}];
			OP_LDAX_D: regs[R_A] = mem_img[{regs[R_D], regs[R_E]}];
			OP_STAX_B: mem_img[{regs[R_B], regs[R_C]}] = regs[R_A];
			OP_STAX_D: mem_img[{regs[R_D], regs[R_E]}] = regs[R_A];
			OP_LDA: regs[R_A] = mem_img[fetch_word()];
			OP_STA: mem_img[fetch_word()] = regs[R_A];
			OP_LHLD: begin
				w = fetch_word();
				regs[R_L] = mem_img[w];
				regs[R_H] = mem_img[w + 16'd1];
			end
			OP_SHLD: begin
				w = fetch_word();
				mem_img[w] = regs[R_L];
				mem_img[w + 16'd1] = regs[R_H];
			end
			OP_XCHG: begin
				t = {regs[R_H], regs[R_L]};
				{regs[R_H], regs[R_L]} = {regs[R_D], regs[R_E]};
				{regs[R_D], regs[R_E]} = t;
			end
			OP_JMP: pc_m = fetch_word();
			OP_CALL: begin
				w = fetch_word();
				push_return(pc_m);
				pc_m = w;
			end
			default: return 1;
		endcase
		return 0;
	endfunction

	function automatic snapshot_t predict_snapshot(input bit [1:0] m, input bit [15:0] a,
			input bit [7:0] d);
		snapshot_t s;
		s.op = 8'h00;
		s.unk = 0;
		case (m)
			MODE_MEM: mem_img[a] = d;
			MODE_EXEC: begin
				s.op = fetch_byte();
				s.unk = execute_op(s.op);
			end
			MODE_FLAG: flags_m = d[3:0];
			default: ;
		endcase
		s.pc = pc_m;
		s.acc = regs[R_A];
		s.b = regs[R_B];
		s.c = regs[R_C];
		s.d = regs[R_D];
		s.e = regs[R_E];
		s.h = regs[R_H];
		s.l = regs[R_L];
		s.sp = sp_m;
		return s;
	endfunction

	task automatic send_item(input logic [1:0] m, input logic [15:0] a, input logic [7:0] d);
		int gap;
		gap = burst_mode ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		address <= a;
		data <= d;
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		@(posedge clk);
		expected_snaps.push_back(predict_snapshot(m, a, d));
		items_sent++;
	endtask

	// places an instruction at the current pc and runs it
	task automatic run_instr(input logic [7:0] op, input logic [7:0] b1 = 8'h00,
			input logic [7:0] b2 = 8'h00);
		logic [15:0] at;
		at = pc_m;
		send_item(MODE_MEM, at, op);
		send_item(MODE_MEM, at + 16'd1, b1);
		send_item(MODE_MEM, at + 16'd2, b2);
		send_item(MODE_EXEC, 16'($urandom), 8'($urandom));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_snaps.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$error("%s expected %0h actual %0h", name, exp_v, act_v);
			mismatches++;
		end
	endtask

	// result side: random stalls, long hold-off on request
	initial begin
		int stall;
		snapshot_t s;
		forever begin
			if (long_hold) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold = 0;
			end
			stall = burst_mode ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(negedge clk);
			while (!out_valid) @(negedge clk);
			if (expected_snaps.size() == 0) begin
				$error("result transfer with nothing expected");
				mismatches++;
			end else begin
				s = expected_snaps.pop_front();
				check_field("pc", s.pc, pc);
				check_field("acc", s.acc, acc);
				check_field("reg_b", s.b, reg_b);
				check_field("reg_c", s.c, reg_c);
				check_field("reg_d", s.d, reg_d);
				check_field("reg_e", s.e, reg_e);
				check_field("reg_h", s.h, reg_h);
				check_field("reg_l", s.l, reg_l);
				check_field("stack_ptr", s.sp, stack_ptr);
				check_field("opcode", s.op, opcode);
				check_field("unknown_op", s.unk, unknown_op);
			end
			@(posedge clk);
		end
	end

	task automatic test_flags_and_modes();
		send_item(MODE_FLAG, 16'h0000, 8'hFF);
		send_item(MODE_FLAG, 16'hFFFF, 8'h00);
		send_item(MODE_NONE, 16'hFFFF, 8'hFF);
		send_item(MODE_MEM, 16'hFFFF, 8'h5A);
	endtask

	task automatic test_transfers();
		run_instr(OP_LXI_H, 8'hFF, 8'hFF);
		run_instr(OP_MVI_M, 8'hA5);
		run_instr(OP_MOV_A_M);
		run_instr(OP_LHLD, 8'hFF, 8'hFF);
		run_instr(OP_XCHG);
		run_instr(OP_HLT);
		run_instr(OP_NOP);
	endtask

	task automatic test_branches();
		send_item(MODE_FLAG, 16'h0000, 8'h00);
		run_instr(OP_JZ, 8'h34, 8'h12);
		run_instr(OP_CALL, 8'h00, 8'h80);
		run_instr(OP_CNZ, 8'hFE, 8'hFF);
	endtask

	task automatic test_backpressure();
		burst_mode = 1;
		long_hold = 1;
		repeat (6) run_instr(8'($urandom), 8'($urandom), 8'($urandom));
		burst_mode = 0;
		wait_drained();
	endtask

	task automatic test_random_streams();
		logic [7:0] picks [12];
		logic [7:0] op;
		picks = '{OP_LXI_B, OP_LXI_D, OP_LXI_SP, OP_STAX_B, OP_LDAX_D, OP_STA, OP_LDA,
			OP_SHLD, OP_JMP, OP_JPE, OP_CM, OP_MOV_M_B};
		while (items_sent < ITEM_TARGET) begin
			if (items_sent % 100 < 4)
				burst_mode = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 3) != 0) begin
				op = ($urandom_range(0, 9) < 6) ? 8'($urandom) : picks[$urandom_range(0, 11)];
				run_instr(op, 8'($urandom), 8'($urandom));
			end else begin
				send_item(2'($urandom), 16'($urandom), 8'($urandom));
			end
		end
		burst_mode = 0;
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		mode <= MODE_MEM;
		address <= 16'h0000;
		data <= 8'h00;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_flags_and_modes();
		test_transfers();
		test_branches();
		test_backpressure();
		test_random_streams();
		in_valid <= 1'b0;
		while (expected_snaps.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (mismatches == 0)
			$display("cpu_move_load_branch_executor regression: pass");
		else
			$display("cpu_move_load_branch_executor regression: fail");
		$finish;
	end
endmodule
`default_nettype wire

// ===== cpu_move_load_branch_executor.f =====
sv/cmlb_pkg.sv
sv/cmlb_mem.sv
sv/cpu_move_load_branch_executor.sv
tb/testbench.sv
